FILE: design/reprojection_residual_jacobian_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the reprojection residual block.
// ----------------------------------------------------------------------------
`ifndef REPROJECTION_RESIDUAL_JACOBIAN_MACROS_SVH
`define REPROJECTION_RESIDUAL_JACOBIAN_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RRJ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RRJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RRJ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RRJ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/rrj_pkg.sv
// ----------------------------------------------------------------------------
// Reprojection residual package
// Formats, codes, delay line words and small arithmetic helpers.
// ----------------------------------------------------------------------------
package rrj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROT_FRAC  = 14;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 35;
    localparam int TR_W      = 34;
    localparam int ROT_W     = 48;
    localparam int DIV_LAT   = 34;
    localparam int NUM_OUT   = 11;

    localparam logic [ROT_W-1:0] ROT_RESET_FIRST  = 48'd16384;
    localparam logic [ROT_W-1:0] ROT_RESET_SECOND = 48'd1073741824;
    localparam logic [ROT_W-1:0] ROT_RESET_THIRD  = 48'd70368744177664;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DEPTH = 2'd1,
        ST_ZERO_TRACE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_ROW_FIRST  = 2'd0,
        CFG_ROW_SECOND = 2'd1,
        CFG_ROW_THIRD  = 2'd2
    } t_cfg_reg;

    // Words that ride alongside the projection and depth term divider banks.
    typedef struct packed {
        logic signed [31:0] pz;
        logic [TR_W-1:0]    tr;
        logic signed [31:0] ou;
        logic signed [31:0] ov;
        t_status            status;
    } t_dla;

    typedef struct packed {
        logic [TR_W-1:0]    tr;
        logic signed [31:0] ou;
        logic signed [31:0] ov;
        t_status            status;
        logic signed [31:0] iz;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_dlb;

    function automatic logic signed [15:0] rot_entry(input logic [ROT_W-1:0] row,
                                                     input int col);
        return row[col*16 +: 16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
        logic signed [31:0] res;
        if (val > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (val < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = val[31:0];
        end
        return res;
    endfunction

endpackage

FILE: design/rrj_div.sv
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Radix-2 restoring divider, one quotient bit per stage, truncating toward
// zero and saturating the quotient to the signed 32-bit range.
// ----------------------------------------------------------------------------
module rrj_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [rrj_pkg::NUM_W-1:0] i_num,
    input  logic signed [rrj_pkg::DEN_W-1:0] i_den,
    output logic signed [31:0]              o_quo
);

    logic [rrj_pkg::NUM_W-1:0]  w_mag;
    logic [rrj_pkg::TR_W-1:0]   w_dmag;

    logic [rrj_pkg::TR_W-1:0]   r_rem [0:32];
    logic [31:0]                r_lo  [0:32];
    logic [31:0]                r_q   [0:32];
    logic [rrj_pkg::TR_W-1:0]   r_d   [0:32];
    logic                       r_neg [0:32];
    logic                       r_ovf [0:32];
    logic signed [31:0]         r_quo;
    logic signed [31:0]         n_quo;

    assign w_mag  = i_num[rrj_pkg::NUM_W-1] ? unsigned'(-i_num) : unsigned'(i_num);
    assign w_dmag = rrj_pkg::TR_W'(i_den[rrj_pkg::DEN_W-1] ? -i_den : i_den);

    // The upper half of the dividend seeds the remainder; if it already
    // reaches the divisor the quotient cannot fit in 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rrj_pkg::TR_W'(w_mag[63:32]);
            r_lo[0]  <= w_mag[31:0];
            r_q[0]   <= '0;
            r_d[0]   <= w_dmag;
            r_neg[0] <= i_num[rrj_pkg::NUM_W-1] ^ i_den[rrj_pkg::DEN_W-1];
            r_ovf[0] <= {2'b00, w_mag[63:32]} >= w_dmag;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_step
        logic [rrj_pkg::TR_W:0] w_t;
        logic [rrj_pkg::TR_W:0] w_diff;
        logic                   w_ge;

        assign w_t    = {r_rem[k], r_lo[k][31]};
        assign w_diff = w_t - {1'b0, r_d[k]};
        assign w_ge   = w_t >= {1'b0, r_d[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? w_diff[rrj_pkg::TR_W-1:0] : w_t[rrj_pkg::TR_W-1:0];
                r_lo[k+1]  <= {r_lo[k][30:0], 1'b0};
                r_q[k+1]   <= {r_q[k][30:0], w_ge};
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        if (!r_neg[32]) begin
            n_quo = (r_ovf[32] || r_q[32][31]) ? 32'sh7FFFFFFF : signed'(r_q[32]);
        end else if (r_ovf[32] || (r_q[32][31] && (r_q[32][30:0] != '0))) begin
            n_quo = 32'sh80000000;
        end else begin
            n_quo = signed'(-r_q[32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: design/reprojection_residual_jacobian.sv
// ----------------------------------------------------------------------------
// Reprojection residual and Jacobian engine
// Takes one word per clock while the output side does not stall and returns one
// result word per item. The latency is set by three 34-stage radix-2 divider
// banks in series (projection, depth terms, trace weighting) plus the input,
// rotation, product and output stages. A stall on the output freezes the whole
// pipeline; the input register still takes a word while it is empty. The user
// must write the rotation rows through the config port only while no item is in
// flight; the block itself does not enforce this. They reset to the identity.
// ----------------------------------------------------------------------------
`include "reprojection_residual_jacobian_macros.svh"

module reprojection_residual_jacobian (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [31:0]      i_trans_x,
    input  logic signed [31:0]      i_trans_y,
    input  logic signed [31:0]      i_trans_z,
    input  logic signed [31:0]      i_point_x,
    input  logic signed [31:0]      i_point_y,
    input  logic signed [31:0]      i_point_z,
    input  logic signed [31:0]      i_obs_u,
    input  logic signed [31:0]      i_obs_v,
    input  logic [31:0]             i_cov_xx,
    input  logic [31:0]             i_cov_yy,
    input  logic [31:0]             i_cov_zz,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [31:0]      o_res_u,
    output logic signed [31:0]      o_res_v,
    output logic signed [31:0]      o_jt_inv_depth,
    output logic signed [31:0]      o_jt_x_term,
    output logic signed [31:0]      o_jt_y_term,
    output logic signed [31:0]      o_jp_u_x,
    output logic signed [31:0]      o_jp_u_y,
    output logic signed [31:0]      o_jp_u_z,
    output logic signed [31:0]      o_jp_v_x,
    output logic signed [31:0]      o_jp_v_y,
    output logic signed [31:0]      o_jp_v_z,
    output logic [1:0]              o_status,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [47:0]             i_cfg_data
);

    localparam int LAT = rrj_pkg::DIV_LAT;
    localparam int F   = rrj_pkg::FRAC_BITS;
    localparam int RF  = rrj_pkg::ROT_FRAC;

    logic [rrj_pkg::ROT_W-1:0] r_rot [3];
    logic                      w_en;

    // Stage 1: input register.
    logic                      r_v1;
    logic signed [31:0]        r_t1 [3];
    logic signed [31:0]        r_x1 [3];
    logic signed [31:0]        r_ou1, r_ov1;
    logic [31:0]               r_cov1 [3];

    // Stage 2: rotation products and trace.
    logic                      r_v2;
    logic signed [47:0]        r_prod [3][3];
    logic signed [31:0]        r_t2 [3];
    logic signed [31:0]        r_ou2, r_ov2;
    logic [rrj_pkg::TR_W-1:0]  r_tr2;

    // Stage 3: transformed point.
    logic                      r_v3;
    logic signed [50:0]        w_sum [3];
    logic signed [31:0]        r_p3 [3];
    logic signed [31:0]        r_ou3, r_ov3;
    logic [rrj_pkg::TR_W-1:0]  r_tr3;
    rrj_pkg::t_status          w_st3;

    // Projection divider bank.
    logic signed [rrj_pkg::NUM_W-1:0] w_num_iz, w_num_u, w_num_v;
    logic signed [rrj_pkg::DEN_W-1:0] w_den_a;
    logic signed [31:0]        w_iz, w_u, w_v;
    rrj_pkg::t_dla             r_dla [LAT];
    logic                      r_va [LAT];

    // Depth term divider bank.
    logic signed [rrj_pkg::NUM_W-1:0] w_num_xt, w_num_yt;
    logic signed [rrj_pkg::DEN_W-1:0] w_den_b;
    logic signed [31:0]        w_xt, w_yt;
    rrj_pkg::t_dlb             r_dlb [LAT];
    logic                      r_vb [LAT];

    // Stage P: Jacobian products.
    logic                      r_vp;
    logic signed [47:0]        r_mi1 [3];
    logic signed [47:0]        r_mi2 [3];
    logic signed [47:0]        r_mx [3];
    logic signed [47:0]        r_my [3];
    logic signed [32:0]        r_du, r_dv;
    logic signed [31:0]        r_izp, r_xtp, r_ytp;
    logic [rrj_pkg::TR_W-1:0]  r_trp;
    rrj_pkg::t_status          r_stp;

    // Stage Q: weighting numerators.
    logic                      r_vq;
    logic signed [34:0]        w_ju [3];
    logic signed [34:0]        w_jv [3];
    logic signed [rrj_pkg::NUM_W-1:0] r_num [rrj_pkg::NUM_OUT];
    logic [rrj_pkg::TR_W-1:0]  r_trq;
    rrj_pkg::t_status          r_stq;

    // Weighting divider bank and output register.
    logic signed [rrj_pkg::DEN_W-1:0] w_den_c;
    logic signed [31:0]        w_quo [rrj_pkg::NUM_OUT];
    rrj_pkg::t_status          r_dlc_st [LAT];
    logic                      r_vc [LAT];
    logic                      r_out_valid;
    logic signed [31:0]        r_out [rrj_pkg::NUM_OUT];
    rrj_pkg::t_status          r_out_st;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= rrj_pkg::ROT_RESET_FIRST;
            r_rot[1] <= rrj_pkg::ROT_RESET_SECOND;
            r_rot[2] <= rrj_pkg::ROT_RESET_THIRD;
        end else if (i_cfg_valid) begin
            unique case (rrj_pkg::t_cfg_reg'(i_cfg_index))
                rrj_pkg::CFG_ROW_FIRST:  r_rot[0] <= i_cfg_data;
                rrj_pkg::CFG_ROW_SECOND: r_rot[1] <= i_cfg_data;
                rrj_pkg::CFG_ROW_THIRD:  r_rot[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The pipeline moves as one whenever the output register can take a word.
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en || !r_v1;

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_t1[0]   <= i_trans_x;
            r_t1[1]   <= i_trans_y;
            r_t1[2]   <= i_trans_z;
            r_x1[0]   <= i_point_x;
            r_x1[1]   <= i_point_y;
            r_x1[2]   <= i_point_z;
            r_ou1     <= i_obs_u;
            r_ov1     <= i_obs_v;
            r_cov1[0] <= i_cov_xx;
            r_cov1[1] <= i_cov_yy;
            r_cov1[2] <= i_cov_zz;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= 48'(rrj_pkg::rot_entry(r_rot[i], j)) * 48'(r_x1[j]);
                end
                r_t2[i] <= r_t1[i];
            end
            r_ou2 <= r_ou1;
            r_ov2 <= r_ov1;
            r_tr2 <= rrj_pkg::TR_W'(r_cov1[0]) + rrj_pkg::TR_W'(r_cov1[1])
                   + rrj_pkg::TR_W'(r_cov1[2]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = ((51'(r_prod[i][0]) + 51'(r_prod[i][1]) + 51'(r_prod[i][2])) >>> RF)
                     + 51'(r_t2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p3[i] <= rrj_pkg::sat32(64'(w_sum[i]));
            end
            r_ou3 <= r_ou2;
            r_ov3 <= r_ov2;
            r_tr3 <= r_tr2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Zero depth is checked before the trace.
    assign w_st3 = (r_p3[2] == '0) ? rrj_pkg::ST_ZERO_DEPTH :
                   (r_tr3 == '0)   ? rrj_pkg::ST_ZERO_TRACE : rrj_pkg::ST_OK;

    // ------------------------------------------------------------------
    // Projection: 1/z, x/z, y/z
    // ------------------------------------------------------------------
    assign w_num_iz = 64'sd1 <<< (2 * F);
    assign w_num_u  = 64'(r_p3[0]) <<< F;
    assign w_num_v  = 64'(r_p3[1]) <<< F;
    assign w_den_a  = 35'(r_p3[2]);

    rrj_div u_div_iz (.i_clk(i_clk), .i_en(w_en), .i_num(w_num_iz), .i_den(w_den_a),
                      .o_quo(w_iz));
    rrj_div u_div_u  (.i_clk(i_clk), .i_en(w_en), .i_num(w_num_u), .i_den(w_den_a),
                      .o_quo(w_u));
    rrj_div u_div_v  (.i_clk(i_clk), .i_en(w_en), .i_num(w_num_v), .i_den(w_den_a),
                      .o_quo(w_v));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dla[0] <= '{pz: r_p3[2], tr: r_tr3, ou: r_ou3, ov: r_ov3, status: w_st3};
            for (int k = 1; k < LAT; k++) begin
                r_dla[k] <= r_dla[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Depth terms: -x/z^2, -y/z^2
    // ------------------------------------------------------------------
    assign w_num_xt = -(64'(w_u) <<< F);
    assign w_num_yt = -(64'(w_v) <<< F);
    assign w_den_b  = 35'(r_dla[LAT-1].pz);

    rrj_div u_div_xt (.i_clk(i_clk), .i_en(w_en), .i_num(w_num_xt), .i_den(w_den_b),
                      .o_quo(w_xt));
    rrj_div u_div_yt (.i_clk(i_clk), .i_en(w_en), .i_num(w_num_yt), .i_den(w_den_b),
                      .o_quo(w_yt));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dlb[0] <= '{tr: r_dla[LAT-1].tr, ou: r_dla[LAT-1].ou, ov: r_dla[LAT-1].ov,
                          status: r_dla[LAT-1].status, iz: w_iz, u: w_u, v: w_v};
            for (int k = 1; k < LAT; k++) begin
                r_dlb[k] <= r_dlb[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage P and stage Q
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_mi1[j] <= 48'(rrj_pkg::rot_entry(r_rot[0], j)) * 48'(r_dlb[LAT-1].iz);
                r_mi2[j] <= 48'(rrj_pkg::rot_entry(r_rot[1], j)) * 48'(r_dlb[LAT-1].iz);
                r_mx[j]  <= 48'(rrj_pkg::rot_entry(r_rot[2], j)) * 48'(w_xt);
                r_my[j]  <= 48'(rrj_pkg::rot_entry(r_rot[2], j)) * 48'(w_yt);
            end
            r_du  <= 33'(r_dlb[LAT-1].u) - 33'(r_dlb[LAT-1].ou);
            r_dv  <= 33'(r_dlb[LAT-1].v) - 33'(r_dlb[LAT-1].ov);
            r_izp <= r_dlb[LAT-1].iz;
            r_xtp <= w_xt;
            r_ytp <= w_yt;
            r_trp <= r_dlb[LAT-1].tr;
            r_stp <= r_dlb[LAT-1].status;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_ju[j] = 35'(r_mi1[j] >>> RF) + 35'(r_mx[j] >>> RF);
            w_jv[j] = 35'(r_mi2[j] >>> RF) + 35'(r_my[j] >>> RF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num[0] <= 64'(r_du) <<< F;
            r_num[1] <= 64'(r_dv) <<< F;
            r_num[2] <= 64'(r_izp) <<< F;
            r_num[3] <= 64'(r_xtp) <<< F;
            r_num[4] <= 64'(r_ytp) <<< F;
            for (int j = 0; j < 3; j++) begin
                r_num[5+j] <= 64'(w_ju[j]) <<< F;
                r_num[8+j] <= 64'(w_jv[j]) <<< F;
            end
            r_trq <= r_trp;
            r_stq <= r_stp;
        end
    end

    // ------------------------------------------------------------------
    // Trace weighting and output register
    // ------------------------------------------------------------------
    assign w_den_c = signed'({1'b0, r_trq});

    for (genvar g = 0; g < rrj_pkg::NUM_OUT; g++) begin : g_wdiv
        rrj_div u_div_w (.i_clk(i_clk), .i_en(w_en), .i_num(r_num[g]), .i_den(w_den_c),
                         .o_quo(w_quo[g]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dlc_st[0] <= r_stq;
            for (int k = 1; k < LAT; k++) begin
                r_dlc_st[k] <= r_dlc_st[k-1];
            end
            r_out_st <= r_dlc_st[LAT-1];
            for (int i = 0; i < rrj_pkg::NUM_OUT; i++) begin
                r_out[i] <= (r_dlc_st[LAT-1] == rrj_pkg::ST_OK) ? w_quo[i] : '0;
            end
        end
    end

    // Valid bits for every bank travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_va[k] <= 1'b0;
                r_vb[k] <= 1'b0;
                r_vc[k] <= 1'b0;
            end
            r_vp        <= 1'b0;
            r_vq        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_va[0] <= r_v3;
            r_vb[0] <= r_va[LAT-1];
            r_vc[0] <= r_vq;
            for (int k = 1; k < LAT; k++) begin
                r_va[k] <= r_va[k-1];
                r_vb[k] <= r_vb[k-1];
                r_vc[k] <= r_vc[k-1];
            end
            r_vp        <= r_vb[LAT-1];
            r_vq        <= r_vp;
            r_out_valid <= r_vc[LAT-1];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_res_u        = r_out[0];
    assign o_res_v        = r_out[1];
    assign o_jt_inv_depth = r_out[2];
    assign o_jt_x_term    = r_out[3];
    assign o_jt_y_term    = r_out[4];
    assign o_jp_u_x       = r_out[5];
    assign o_jp_u_y       = r_out[6];
    assign o_jp_u_z       = r_out[7];
    assign o_jp_v_x       = r_out[8];
    assign o_jp_v_y       = r_out[9];
    assign o_jp_v_z       = r_out[10];
    assign o_status       = r_out_st;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RRJ_ASSERT_IMPL(a_err_zeroes, i_clk, i_rst_n, o_valid && (r_out_st != rrj_pkg::ST_OK), o_res_u == '0 && o_jt_inv_depth == '0 && o_jp_v_z == '0)
    `RRJ_ASSERT_IMPL(a_ok_has_trace, i_clk, i_rst_n, r_vp && (r_stp == rrj_pkg::ST_OK), r_trp != '0)
    `RRJ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_dlc_st[LAT-1]) && $stable(r_vc[LAT-1]))

endmodule
